// File: sv/dtq_pkg.sv
`default_nettype none
package dtq_pkg;

  localparam logic [1:0] OP_SUBMIT = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_STOP   = 2'd3;

  localparam logic [1:0] CODE_EXPIRED = 2'd0;
  localparam logic [1:0] CODE_STOPPED = 2'd1;
  localparam logic [1:0] CODE_FULL    = 2'd2;

endpackage
`default_nettype wire

// File: sv/dtq_if.sv
`default_nettype none
interface dtq_in_if #(
  parameter int TIME_BITS = 32,
  parameter int ID_BITS   = 8
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           operation;
  logic [ID_BITS-1:0]   timer_id;
  logic [TIME_BITS-1:0] deadline;
  logic [TIME_BITS-1:0] now;

  modport source (output valid, operation, timer_id, deadline, now, input ready);
  modport sink   (input valid, operation, timer_id, deadline, now, output ready);
endinterface

interface dtq_out_if #(
  parameter int ID_BITS = 8
);
  logic               valid;
  logic               ready;
  logic [ID_BITS-1:0] done_id;
  logic [1:0]         completion;
  logic               last;

  modport source (output valid, done_id, completion, last, input ready);
  modport sink   (input valid, done_id, completion, last, output ready);
endinterface
`default_nettype wire

// File: sv/dtq_mem.sv
`default_nettype none
module dtq_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 40,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: sv/dtq_ctrl.sv
`default_nettype none
module dtq_ctrl #(
  parameter int DEPTH     = 16,
  parameter int TIME_BITS = 32,
  parameter int ID_BITS   = 8,
  parameter int IW        = 4,
  parameter int CW        = 5
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  dtq_in_if.sink                            in_ch,
  dtq_out_if.source                         out_ch,
  output logic                              mem_rd_en,
  output logic [IW-1:0]                     mem_raddr,
  input  wire logic [TIME_BITS+ID_BITS-1:0] mem_rdata,
  output logic                              mem_wr_en,
  output logic [IW-1:0]                     mem_waddr,
  output logic [TIME_BITS+ID_BITS-1:0]      mem_wdata
);
  import dtq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SC_RD, S_SC_EV, S_SC_DONE, S_SH_RD, S_SH_WR, S_WR_NEW,
    S_CSH_RD, S_CSH_WR, S_CFIN, S_EX_RD, S_EX_EV, S_FIN
  } state_t;

  state_t               state;
  logic [1:0]           op;
  logic [ID_BITS-1:0]   id;
  logic [TIME_BITS-1:0] dl;
  logic [TIME_BITS-1:0] tnow;
  logic [CW-1:0]        idx;
  logic [CW-1:0]        pos;
  logic [CW-1:0]        fpos;
  logic                 found;
  logic                 posset;
  logic [IW-1:0]        head;
  logic [CW-1:0]        count;

  logic                 hold_valid;
  logic [ID_BITS-1:0]   hold_id;
  logic [1:0]           hold_code;
  logic                 out_valid;
  logic [ID_BITS-1:0]   out_id;
  logic [1:0]           out_code;
  logic                 out_last;

  logic [TIME_BITS-1:0] e_dl;
  logic [ID_BITS-1:0]   e_id;
  logic                 out_free;
  logic                 emit_ok;
  logic                 emit_req;
  logic [ID_BITS-1:0]   emit_id;
  logic [1:0]           emit_code;
  logic                 emit_push;
  logic                 fin_push;
  logic                 due;
  logic                 sub_emit;
  logic [CW-1:0]        idx_inc;

  // logical slot to physical address in the ring
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] h, input logic [CW-1:0] off);
    logic [IW:0] s;
    s = {1'b0, h} + (IW+1)'(off);
    if (s >= (IW+1)'(DEPTH)) s = s - (IW+1)'(DEPTH);
    return s[IW-1:0];
  endfunction

  assign e_dl      = mem_rdata[TIME_BITS+ID_BITS-1:ID_BITS];
  assign e_id      = mem_rdata[ID_BITS-1:0];
  assign out_free  = !out_valid || out_ch.ready;
  assign emit_ok   = !hold_valid || out_free;
  assign emit_push = emit_req && emit_ok && hold_valid;
  assign fin_push  = (state == S_FIN) && hold_valid && out_free;
  assign due       = (op == OP_STOP) || (e_dl <= tnow);
  assign sub_emit  = (op == OP_SUBMIT) && !found && ((dl <= tnow) || (count == CW'(DEPTH)));
  assign idx_inc   = idx + CW'(1);

  assign in_ch.ready       = (state == S_IDLE);
  assign out_ch.valid      = out_valid;
  assign out_ch.done_id    = out_id;
  assign out_ch.completion = out_code;
  assign out_ch.last       = out_last;

  always_comb begin
    mem_rd_en = 1'b0;
    mem_raddr = head;
    mem_wr_en = 1'b0;
    mem_waddr = phys(head, idx);
    mem_wdata = mem_rdata;
    emit_req  = 1'b0;
    emit_id   = id;
    emit_code = CODE_EXPIRED;
    unique case (state)
      S_SC_RD: begin
        mem_rd_en = 1'b1;
        mem_raddr = phys(head, idx);
      end
      S_SC_DONE: begin
        emit_req  = sub_emit;
        emit_code = (dl <= tnow) ? CODE_EXPIRED : CODE_FULL;
      end
      S_SH_RD: begin
        mem_rd_en = 1'b1;
        mem_raddr = phys(head, idx - CW'(1));
      end
      S_SH_WR: mem_wr_en = 1'b1;
      S_WR_NEW: begin
        mem_wr_en = 1'b1;
        mem_waddr = phys(head, pos);
        mem_wdata = {dl, id};
      end
      S_CSH_RD: begin
        mem_rd_en = 1'b1;
        mem_raddr = phys(head, idx_inc);
      end
      S_CSH_WR: mem_wr_en = 1'b1;
      S_CFIN: begin
        emit_req  = 1'b1;
        emit_code = CODE_STOPPED;
      end
      S_EX_RD: mem_rd_en = (count != '0);
      S_EX_EV: begin
        emit_req  = due;
        emit_id   = e_id;
        emit_code = (op == OP_STOP) ? CODE_STOPPED : CODE_EXPIRED;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      count      <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (emit_push || fin_push) begin
        out_valid <= 1'b1;
        out_id    <= hold_id;
        out_code  <= hold_code;
        out_last  <= fin_push;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end

      // one result is held back so that the final one can carry last
      if (emit_req && emit_ok) begin
        hold_valid <= 1'b1;
        hold_id    <= emit_id;
        hold_code  <= emit_code;
      end else if (fin_push) begin
        hold_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            op     <= in_ch.operation;
            id     <= in_ch.timer_id;
            dl     <= in_ch.deadline;
            tnow   <= in_ch.now;
            idx    <= '0;
            pos    <= count;
            found  <= 1'b0;
            posset <= 1'b0;
            if (in_ch.operation == OP_SUBMIT || in_ch.operation == OP_CANCEL) begin
              state <= (count == '0) ? S_SC_DONE : S_SC_RD;
            end else begin
              state <= S_EX_RD;
            end
          end
        end
        S_SC_RD: state <= S_SC_EV;
        S_SC_EV: begin
          if (e_id == id) begin
            found <= 1'b1;
            fpos  <= idx;
          end
          if (!posset && !((e_dl < dl) || ((e_dl == dl) && (e_id < id)))) begin
            pos    <= idx;
            posset <= 1'b1;
          end
          idx   <= idx_inc;
          state <= (idx_inc == count) ? S_SC_DONE : S_SC_RD;
        end
        S_SC_DONE: begin
          if (op == OP_SUBMIT) begin
            if (found) begin
              state <= S_EX_RD;
            end else if (sub_emit) begin
              if (emit_ok) state <= S_EX_RD;
            end else begin
              idx   <= count;
              state <= (count == pos) ? S_WR_NEW : S_SH_RD;
            end
          end else begin
            if (!found) begin
              state <= S_EX_RD;
            end else begin
              idx   <= fpos;
              state <= (fpos + CW'(1) < count) ? S_CSH_RD : S_CFIN;
            end
          end
        end
        S_SH_RD: state <= S_SH_WR;
        S_SH_WR: begin
          idx   <= idx - CW'(1);
          state <= (idx - CW'(1) == pos) ? S_WR_NEW : S_SH_RD;
        end
        S_WR_NEW: begin
          count <= count + CW'(1);
          state <= S_EX_RD;
        end
        S_CSH_RD: state <= S_CSH_WR;
        S_CSH_WR: begin
          idx   <= idx_inc;
          state <= (idx + CW'(2) == count) ? S_CFIN : S_CSH_RD;
        end
        S_CFIN: begin
          if (emit_ok) begin
            count <= count - CW'(1);
            state <= S_EX_RD;
          end
        end
        S_EX_RD: state <= (count == '0) ? S_FIN : S_EX_EV;
        S_EX_EV: begin
          if (!due) begin
            state <= S_FIN;
          end else if (emit_ok) begin
            head  <= phys(head, CW'(1));
            count <= count - CW'(1);
            state <= S_EX_RD;
          end
        end
        S_FIN: begin
          if (!hold_valid || out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sv/deadline_timer_queue_top.sv
// Channel  Dir  Payload                                 Handshake
// in_ch    in   operation, timer_id, deadline, now      valid/ready
// out_ch   out  done_id, completion, last               valid/ready
//
// One item at a time: the sequencer scans each pending entry for the id and
// insert position, moves entries on insert or cancel, expires or flushes
// entries from the head, and steps through accept, decision, new-entry write,
// head check and last flush, one memory access a cycle with a registered read.
// Reset (rst, synchronous) empties the queue; memory contents are not cleared.
// A stalled out_ch holds the sequencer at its next completion; in_ch is
// ready again once the last completion of an item sits in the output register.
`default_nettype none
module deadline_timer_queue_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 32,
  parameter int ID_BITS     = 8
) (
  input wire logic  clk,
  input wire logic  rst,
  dtq_in_if.sink    in_ch,
  dtq_out_if.source out_ch
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = TIME_BITS + ID_BITS;

  logic          rd_en;
  logic [IW-1:0] raddr;
  logic [EW-1:0] rdata;
  logic          wr_en;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdata;

  dtq_mem #(.DEPTH(QUEUE_DEPTH), .WIDTH(EW), .AW(IW)) u_mem (
    .clk(clk), .rd_en(rd_en), .raddr(raddr), .rdata(rdata),
    .wr_en(wr_en), .waddr(waddr), .wdata(wdata)
  );

  dtq_ctrl #(
    .DEPTH(QUEUE_DEPTH), .TIME_BITS(TIME_BITS), .ID_BITS(ID_BITS), .IW(IW), .CW(CW)
  ) u_ctrl (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .mem_rd_en(rd_en), .mem_raddr(raddr), .mem_rdata(rdata),
    .mem_wr_en(wr_en), .mem_waddr(waddr), .mem_wdata(wdata)
  );

endmodule
`default_nettype wire

// File: sv/dtq_checker.sv
`default_nettype none
module dtq_checker #(
  parameter int ID_BITS = 8
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [ID_BITS-1:0] out_done_id,
  input wire logic [1:0]         out_completion
);
  import dtq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_done_id))
    else $error("result dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while previous still in work");

  a_code_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_completion == CODE_EXPIRED || out_completion == CODE_STOPPED ||
                   out_completion == CODE_FULL))
    else $error("bad completion code");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind deadline_timer_queue_top dtq_checker #(.ID_BITS(ID_BITS)) u_dtq_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_done_id(out_ch.done_id), .out_completion(out_ch.completion)
);
`default_nettype wire

// File: sim/dtq_checker.sv
module dtq_scoreboard #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 32,
  parameter int ID_BITS     = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic [1:0]         in_operation,
  input  wire logic [ID_BITS-1:0] in_timer_id,
  input  wire logic [TIME_BITS-1:0] in_deadline,
  input  wire logic [TIME_BITS-1:0] in_now,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic [ID_BITS-1:0] out_done_id,
  input  wire logic [1:0]         out_completion,
  input  wire logic               out_last,
  output int                      failures,
  output int                      pending_results
);
  import dtq_pkg::*;

  typedef struct packed {
    logic [ID_BITS-1:0] done_id;
    logic [1:0]         completion;
    logic               last;
  } completion_t;

  logic [TIME_BITS-1:0] q_deadline [QUEUE_DEPTH];
  logic [ID_BITS-1:0]   q_id       [QUEUE_DEPTH];
  int                   q_count;
  completion_t          expected_q [$];

  assign pending_results = expected_q.size();

  function automatic int locate(logic [ID_BITS-1:0] id);
    for (int k = 0; k < q_count; k++)
      if (q_id[k] == id) return k;
    return -1;
  endfunction

  function automatic void remove_at(int pos);
    for (int k = pos; k + 1 < q_count; k++) begin
      q_deadline[k] = q_deadline[k+1];
      q_id[k]       = q_id[k+1];
    end
    q_count--;
  endfunction

  function automatic void predict_completions(logic [1:0] op, logic [ID_BITS-1:0] id,
                                              logic [TIME_BITS-1:0] dl,
                                              logic [TIME_BITS-1:0] now);
    completion_t batch [$];
    int pos;
    if (op == OP_STOP) begin
      while (q_count > 0) begin
        batch.insert(batch.size(), completion_t'{q_id[0], CODE_STOPPED, 1'b0});
        remove_at(0);
      end
    end else begin
      if (op == OP_SUBMIT && locate(id) < 0) begin
        if (dl <= now) batch.insert(batch.size(), completion_t'{id, CODE_EXPIRED, 1'b0});
        else if (q_count >= QUEUE_DEPTH)
          batch.insert(batch.size(), completion_t'{id, CODE_FULL, 1'b0});
        else begin
          pos = 0;
          while (pos < q_count && (q_deadline[pos] < dl ||
                 (q_deadline[pos] == dl && q_id[pos] < id))) pos++;
          for (int k = q_count; k > pos; k--) begin
            q_deadline[k] = q_deadline[k-1];
            q_id[k]       = q_id[k-1];
          end
          q_deadline[pos] = dl;
          q_id[pos]       = id;
          q_count++;
        end
      end else if (op == OP_CANCEL) begin
        pos = locate(id);
        if (pos >= 0) begin
          remove_at(pos);
          batch.insert(batch.size(), completion_t'{id, CODE_STOPPED, 1'b0});
        end
      end
      while (q_count > 0 && q_deadline[0] <= now) begin
        batch.insert(batch.size(), completion_t'{q_id[0], CODE_EXPIRED, 1'b0});
        remove_at(0);
      end
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) expected_q.insert(expected_q.size(), batch[i]);
  endfunction

  initial failures = 0;

  always @(posedge clk) begin
    completion_t exp_c;
    if (rst) begin
      q_count = 0;
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected completion id=%0d code=%0d last=%0b", $time,
                   out_done_id, out_completion, out_last);
          failures++;
        end else begin
          exp_c = expected_q.pop_front();
          if (exp_c.done_id !== out_done_id || exp_c.completion !== out_completion ||
              exp_c.last !== out_last) begin
            $display("%0t: mismatch expected id=%0d code=%0d last=%0b, got id=%0d code=%0d last=%0b",
                     $time, exp_c.done_id, exp_c.completion, exp_c.last,
                     out_done_id, out_completion, out_last);
            failures++;
          end
        end
      end
      if (in_valid && in_ready)
        predict_completions(in_operation, in_timer_id, in_deadline, in_now);
    end
  end
endmodule

// File: sim/testbench.sv
module testbench;
  import dtq_pkg::*;

  localparam int DEPTH = 16;
  localparam longint CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   failures, pending_results;
  int   send_idle_pct = 0, stall_pct = 0;
  bit   hold_off = 1'b0;
  longint cycles = 0;
  logic [31:0] clock_now = 0;

  dtq_in_if  #(.TIME_BITS(32), .ID_BITS(8)) in_ch ();
  dtq_out_if #(.ID_BITS(8))                 out_ch ();

  deadline_timer_queue_top #(.QUEUE_DEPTH(DEPTH), .TIME_BITS(32), .ID_BITS(8)) dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  dtq_scoreboard #(.QUEUE_DEPTH(DEPTH), .TIME_BITS(32), .ID_BITS(8)) checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_operation(in_ch.operation),
    .in_timer_id(in_ch.timer_id), .in_deadline(in_ch.deadline), .in_now(in_ch.now),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_done_id(out_ch.done_id),
    .out_completion(out_ch.completion), .out_last(out_ch.last),
    .failures(failures), .pending_results(pending_results)
  );

  always #10 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_TICK;
    in_ch.timer_id = '0;
    in_ch.deadline = '0;
    in_ch.now = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk)
    out_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);

  // returns right after the accepting edge; valid stays up until the next call
  // or release_input changes it at the following falling edge
  task automatic send_item(logic [1:0] op, logic [7:0] id, logic [31:0] dl,
                           logic [31:0] now);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.timer_id  <= id;
    in_ch.deadline  <= dl;
    in_ch.now       <= now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    release_input();
    while (pending_results != 0) @(negedge clk);
  endtask

  // well-formed random item: time never moves back, deadlines mostly near the current time
  task automatic random_item();
    logic [1:0] op;
    logic [7:0] id;
    logic [31:0] dl;
    int r;
    r = $urandom_range(99);
    id = 8'($urandom_range(23));
    if ($urandom_range(9) == 0) id = 8'($urandom);
    clock_now = clock_now + $urandom_range(6);
    dl = clock_now + $urandom_range(40) - 3;
    if (r < 55) op = OP_SUBMIT;
    else if (r < 75) op = OP_CANCEL;
    else if (r < 95) op = OP_TICK;
    else op = OP_STOP;
    if ($urandom_range(19) == 0) dl = $urandom;
    send_item(op, id, dl, clock_now);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, immediate expiry, ties, full queue, duplicates, cancel, stop
    send_item(OP_SUBMIT, 8'hFF, 32'h0, 32'h0);
    send_item(OP_SUBMIT, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_item(OP_SUBMIT, 8'h00, 32'h5, 32'h0);
    send_item(OP_TICK, 8'hAA, 32'h5555_5555, 32'hFFFF_FFFF);
    for (int i = 0; i < DEPTH; i++)
      send_item(OP_SUBMIT, 8'(DEPTH - i), 32'd100 + 32'(i % 3), 32'd1);
    send_item(OP_SUBMIT, 8'hFE, 32'd200, 32'd2);
    send_item(OP_SUBMIT, 8'd5, 32'd50, 32'd2);
    send_item(OP_CANCEL, 8'd7, 32'h0, 32'd3);
    send_item(OP_CANCEL, 8'd7, 32'h0, 32'd3);
    send_item(OP_STOP, 8'h55, 32'hAAAA_AAAA, 32'h0);
    send_item(OP_STOP, 8'h0, 32'h0, 32'h0);
    wait_drained();

    // random phases with different idling patterns
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 74; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 74; end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      for (int i = 0; i < 70; i++) random_item();
      if (ph == 1) begin
        // receiver holds off while the queue fills and later items pile up
        send_idle_pct = 0;
        fork
          begin
            hold_off = 1'b1;
            repeat (400) @(negedge clk);
            hold_off = 1'b0;
          end
          begin
            for (int i = 0; i < 18; i++)
              send_item(OP_SUBMIT, 8'(100 + i), clock_now + 1000, clock_now);
            clock_now = clock_now + 2000;
            send_item(OP_TICK, 8'h0, 32'h0, clock_now);
            release_input();
          end
        join
      end
      wait_drained();
    end

    send_item(OP_TICK, 8'h0, 32'h0, 32'hFFFF_FFFF);
    wait_drained();
    repeat (200) @(negedge clk);
    if (failures == 0 && pending_results == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

// File: files.f
sv/dtq_pkg.sv
sv/dtq_if.sv
sv/dtq_mem.sv
sv/dtq_ctrl.sv
sv/deadline_timer_queue_top.sv
sv/dtq_checker.sv
sim/dtq_checker.sv
sim/testbench.sv
